// ===== rtl/tank_level_pump_alarm_controller_core_defines.svh =====
// Assertion macros for the tank level pump and alarm controller.
// Used by the top level; no other dependencies.
`ifndef TANK_LEVEL_PUMP_ALARM_CONTROLLER_CORE_DEFINES_SVH
`define TANK_LEVEL_PUMP_ALARM_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define TLPAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while in reset.
`define TLPAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLPAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TLPAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/tlpac_pkg.sv =====
// Shared types and constants of the tank level pump and alarm controller.
// No dependencies; imported by tlpac_step and the top level.
package tlpac_pkg;

	localparam int TIMER_BITS = 16;
	localparam int RUN_BITS = 16;
	localparam int CMP_W = (TIMER_BITS > RUN_BITS) ? TIMER_BITS : RUN_BITS;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] VALVE_CLOSED = 8'd0;
	localparam logic [7:0] VALVE_HALF = 8'd90;
	localparam logic [7:0] VALVE_LIMIT = 8'd180;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_ECHO = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL_THRESHOLD = 3'd0,
		CFG_PUMP_RUN = 3'd1,
		CFG_BUZZER_RUN = 3'd2,
		CFG_ERROR_LIMIT = 3'd3,
		CFG_MANUAL_ENABLE = 3'd4,
		CFG_MANUAL_VALVE = 3'd5,
		CFG_MANUAL_PUMP = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [14:0] level_threshold_us;
		logic [RUN_BITS-1:0] pump_run_ms;
		logic [RUN_BITS-1:0] buzzer_run_ms;
		logic [7:0] error_limit;
		logic manual_enable;
		logic signed [8:0] manual_valve_angle;
		logic manual_pump_request;
	} cfg_t;

	typedef struct packed {
		logic pump_running;
		logic pump_lock;
		logic [TIMER_BITS-1:0] pump_elapsed;
		logic buzzer_active;
		logic buzzer_lock;
		logic [TIMER_BITS-1:0] buzzer_elapsed;
		logic [7:0] valve_position;
		logic [7:0] miss_counter;
	} state_t;

	typedef struct packed {
		logic pump_on;
		logic buzzer_on;
		logic [7:0] valve_angle;
		logic pump_locked;
		logic buzzer_locked;
		logic reading_used;
		logic [7:0] miss_count;
	} result_t;

endpackage

// ===== rtl/tlpac_step.sv =====
// Next-state logic for one tick or echo measurement.
// Depends on tlpac_pkg; purely combinational.
module tlpac_step (
	input  tlpac_pkg::cfg_t   cfg,
	input  tlpac_pkg::state_t cur,
	input  logic              req_type,
	input  logic [14:0]       echo_us,
	output tlpac_pkg::state_t nxt,
	output logic              used
);
	import tlpac_pkg::*;

	logic [8:0] miss_inc;
	logic [7:0] miss_sat;
	logic [TIMER_BITS-1:0] pump_e;
	logic [TIMER_BITS-1:0] buzzer_e;
	logic pump_end;
	logic buzzer_end;
	logic high;

	// Elapsed counters saturate; a run ends at its length or at saturation.
	assign pump_e = (cur.pump_elapsed == TIMER_MAX) ? cur.pump_elapsed
		: cur.pump_elapsed + 1'b1;
	assign buzzer_e = (cur.buzzer_elapsed == TIMER_MAX) ? cur.buzzer_elapsed
		: cur.buzzer_elapsed + 1'b1;
	assign pump_end = (CMP_W'(pump_e) >= CMP_W'(cfg.pump_run_ms)) || (pump_e == TIMER_MAX);
	assign buzzer_end = (CMP_W'(buzzer_e) >= CMP_W'(cfg.buzzer_run_ms))
		|| (buzzer_e == TIMER_MAX);

	assign miss_inc = {1'b0, cur.miss_counter} + 9'd1;
	assign miss_sat = miss_inc[8] ? 8'hFF : miss_inc[7:0];

	always_comb begin
		nxt = cur;
		used = 1'b0;
		high = 1'b0;
		if (req_type == REQ_TICK) begin
			if (cur.pump_running) begin
				nxt.pump_elapsed = pump_e;
				if (pump_end) begin
					nxt.pump_running = 1'b0;
					nxt.pump_lock = 1'b1;
				end
			end
			if (cur.buzzer_active) begin
				nxt.buzzer_elapsed = buzzer_e;
				if (buzzer_end) begin
					nxt.buzzer_active = 1'b0;
					nxt.buzzer_lock = 1'b1;
				end
			end
		end else begin
			if (echo_us == 15'd0) begin
				// Once the miss count reaches the limit, a miss acts as a low level.
				if (miss_sat >= cfg.error_limit) begin
					nxt.miss_counter = cfg.error_limit;
					used = 1'b1;
				end else begin
					nxt.miss_counter = miss_sat;
				end
			end else begin
				nxt.miss_counter = 8'd0;
				used = 1'b1;
				high = echo_us > cfg.level_threshold_us;
			end

			if (used) begin
				if (!cfg.manual_enable) begin
					if (high) begin
						nxt.pump_lock = 1'b0;
						nxt.buzzer_lock = 1'b0;
						nxt.buzzer_active = 1'b0;
						nxt.buzzer_elapsed = '0;
						nxt.valve_position = VALVE_CLOSED;
					end else begin
						nxt.valve_position = VALVE_HALF;
						if (!cur.pump_running && !cur.pump_lock) begin
							nxt.pump_running = 1'b1;
							nxt.pump_elapsed = '0;
						end
						if (!cur.buzzer_active && !cur.buzzer_lock) begin
							nxt.buzzer_active = 1'b1;
							nxt.buzzer_elapsed = '0;
						end
					end
				end else begin
					// A negative angle leaves the valve where it is.
					if (!cfg.manual_valve_angle[8]) begin
						nxt.valve_position = (cfg.manual_valve_angle[7:0] > VALVE_LIMIT)
							? VALVE_LIMIT : cfg.manual_valve_angle[7:0];
					end
					if (cfg.manual_pump_request && !cur.pump_running) begin
						nxt.pump_running = 1'b1;
						nxt.pump_elapsed = '0;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/tank_level_pump_alarm_controller_core.sv =====
// Top level of the tank level pump and alarm controller.
// Depends on tlpac_pkg, tlpac_step and the assertion macro header.
`include "tank_level_pump_alarm_controller_core_defines.svh"

// Every input transfer (a millisecond tick or an echo measurement) yields exactly
// one result transfer that shows the controller state after that event. The block
// accepts one item per cycle while the skid entry is free: the item sits in an
// input register while the control logic updates the state and the result
// register is loaded. A two-entry output buffer (result register plus one
// skid entry) lets the input side keep accepting while a result waits; input ready
// drops only while that skid entry is full. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and take effect on the next processed item;
// indexes beyond the register list are ignored. There is no clearing pass after reset.
module tank_level_pump_alarm_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [14:0]                         echo_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pump_on,
	output logic                                buzzer_on,
	output logic [7:0]                          valve_angle,
	output logic                                pump_locked,
	output logic                                buzzer_locked,
	output logic                                reading_used,
	output logic [7:0]                          miss_count,
	input  logic                                cfg_we,
	input  logic [tlpac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlpac_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tlpac_pkg::*;

	cfg_t cfg_q;
	state_t state_q;
	state_t state_nxt;
	logic step_used;

	logic v_s1;
	logic req_s1;
	logic [14:0] echo_s1;

	result_t out_q;
	result_t skid_q;
	result_t res;
	logic out_valid_q;
	logic skid_valid_q;
	logic adv;
	logic in_xfer;
	logic out_xfer;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold_us <= 15'd291;
			cfg_q.pump_run_ms <= 16'd2000;
			cfg_q.buzzer_run_ms <= 16'd2000;
			cfg_q.error_limit <= 8'd5;
			cfg_q.manual_enable <= 1'b0;
			cfg_q.manual_valve_angle <= 9'h1FF;
			cfg_q.manual_pump_request <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL_THRESHOLD: cfg_q.level_threshold_us <= cfg_data[14:0];
				CFG_PUMP_RUN:        cfg_q.pump_run_ms <= cfg_data[RUN_BITS-1:0];
				CFG_BUZZER_RUN:      cfg_q.buzzer_run_ms <= cfg_data[RUN_BITS-1:0];
				CFG_ERROR_LIMIT:     cfg_q.error_limit <= cfg_data[7:0];
				CFG_MANUAL_ENABLE:   cfg_q.manual_enable <= cfg_data[0];
				CFG_MANUAL_VALVE:    cfg_q.manual_valve_angle <= cfg_data[8:0];
				CFG_MANUAL_PUMP:     cfg_q.manual_pump_request <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The input stage advances whenever the skid entry is free.
	assign adv = v_s1 && !skid_valid_q;
	assign in_ready = !v_s1 || adv;
	assign in_xfer = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1 <= req_type;
			echo_s1 <= echo_us;
		end
	end

	tlpac_step u_step (
		.cfg      (cfg_q),
		.cur      (state_q),
		.req_type (req_s1),
		.echo_us  (echo_s1),
		.nxt      (state_nxt),
		.used     (step_used)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pump_running <= 1'b0;
			state_q.pump_lock <= 1'b0;
			state_q.pump_elapsed <= '0;
			state_q.buzzer_active <= 1'b0;
			state_q.buzzer_lock <= 1'b0;
			state_q.buzzer_elapsed <= '0;
			state_q.valve_position <= VALVE_HALF;
			state_q.miss_counter <= 8'd0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		res.pump_on = state_nxt.pump_running;
		res.buzzer_on = state_nxt.buzzer_active;
		res.valve_angle = state_nxt.valve_position;
		res.pump_locked = state_nxt.pump_lock;
		res.buzzer_locked = state_nxt.buzzer_lock;
		res.reading_used = step_used;
		res.miss_count = state_nxt.miss_counter;
	end

	// Output buffer: a new result goes to the skid entry only when the result
	// register is full and not being drained in this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_xfer) begin
				out_valid_q <= skid_valid_q || adv;
				skid_valid_q <= 1'b0;
			end else if (adv) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_xfer) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (adv) begin
				out_q <= res;
			end
		end else if (adv) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign pump_on = out_q.pump_on;
	assign buzzer_on = out_q.buzzer_on;
	assign valve_angle = out_q.valve_angle;
	assign pump_locked = out_q.pump_locked;
	assign buzzer_locked = out_q.buzzer_locked;
	assign reading_used = out_q.reading_used;
	assign miss_count = out_q.miss_count;

	`TLPAC_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid entry holds a result while the result register is empty")
	`TLPAC_ASSERT_IMPL(a_valve_range, clk, arst_n, 1'b1, state_q.valve_position <= VALVE_LIMIT, "valve position above its limit")
	`TLPAC_ASSERT_IMPL(a_buzzer_timer, clk, arst_n, state_q.buzzer_active, state_q.buzzer_elapsed != TIMER_MAX, "buzzer still active with a saturated timer")
	`TLPAC_ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_valid_q && out_ready, !skid_valid_q, "skid entry not drained by a result transfer")

endmodule

// ===== verif/tank_level_pump_alarm_controller_core_test.sv =====
// Self-checking testbench for tank_level_pump_alarm_controller_core.
// Holds a status tracker class that predicts every result from the accepted events.
// Depends on tlpac_pkg and the RTL of the block under test.
import tlpac_pkg::*;

class pump_alarm_tracker;
	cfg_t cfg;
	logic pump_running, pump_lock, buzzer_active, buzzer_lock;
	logic [TIMER_BITS-1:0] pump_elapsed, buzzer_elapsed;
	logic [7:0] valve_position, miss_counter;
	result_t expected_status[$];
	int mismatches;

	function new();
		cfg.level_threshold_us = 15'd291;
		cfg.pump_run_ms = 16'd2000;
		cfg.buzzer_run_ms = 16'd2000;
		cfg.error_limit = 8'd5;
		cfg.manual_enable = 1'b0;
		cfg.manual_valve_angle = 9'h1FF;
		cfg.manual_pump_request = 1'b0;
		pump_running = 1'b0;
		pump_lock = 1'b0;
		pump_elapsed = '0;
		buzzer_active = 1'b0;
		buzzer_lock = 1'b0;
		buzzer_elapsed = '0;
		valve_position = VALVE_HALF;
		miss_counter = 8'd0;
		mismatches = 0;
	endfunction

	function void set_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_LEVEL_THRESHOLD: cfg.level_threshold_us = data[14:0];
			CFG_PUMP_RUN: cfg.pump_run_ms = data[RUN_BITS-1:0];
			CFG_BUZZER_RUN: cfg.buzzer_run_ms = data[RUN_BITS-1:0];
			CFG_ERROR_LIMIT: cfg.error_limit = data[7:0];
			CFG_MANUAL_ENABLE: cfg.manual_enable = data[0];
			CFG_MANUAL_VALVE: cfg.manual_valve_angle = data[8:0];
			CFG_MANUAL_PUMP: cfg.manual_pump_request = data[0];
			default: ;
		endcase
	endfunction

	// A run ends once the saturating counter reaches the run length or its own maximum.
	function bit advance_run(inout logic [TIMER_BITS-1:0] elapsed,
			input logic [RUN_BITS-1:0] run_len);
		if (elapsed != TIMER_MAX)
			elapsed = elapsed + 1'b1;
		return (elapsed >= run_len) || (elapsed == TIMER_MAX);
	endfunction

	function void note_event(req_t req, logic [14:0] echo);
		logic used, high;
		logic [8:0] bumped;
		result_t r;
		used = 1'b0;
		high = 1'b0;
		if (req == REQ_TICK) begin
			if (pump_running && advance_run(pump_elapsed, cfg.pump_run_ms)) begin
				pump_running = 1'b0;
				pump_lock = 1'b1;
			end
			if (buzzer_active && advance_run(buzzer_elapsed, cfg.buzzer_run_ms)) begin
				buzzer_active = 1'b0;
				buzzer_lock = 1'b1;
			end
		end else begin
			if (echo == 15'd0) begin
				bumped = {1'b0, miss_counter} + 9'd1;
				if (bumped > 9'd255)
					bumped = 9'd255;
				if (bumped >= {1'b0, cfg.error_limit}) begin
					miss_counter = cfg.error_limit;
					used = 1'b1;
				end else begin
					miss_counter = bumped[7:0];
				end
			end else begin
				miss_counter = 8'd0;
				used = 1'b1;
				high = echo > cfg.level_threshold_us;
			end
			if (used && !cfg.manual_enable) begin
				if (high) begin
					pump_lock = 1'b0;
					buzzer_lock = 1'b0;
					buzzer_active = 1'b0;
					buzzer_elapsed = '0;
					valve_position = VALVE_CLOSED;
				end else begin
					valve_position = VALVE_HALF;
					if (!pump_running && !pump_lock) begin
						pump_running = 1'b1;
						pump_elapsed = '0;
					end
					if (!buzzer_active && !buzzer_lock) begin
						buzzer_active = 1'b1;
						buzzer_elapsed = '0;
					end
				end
			end else if (used) begin
				// A negative angle leaves the valve where it is.
				if (!cfg.manual_valve_angle[8])
					valve_position = (cfg.manual_valve_angle[7:0] > VALVE_LIMIT) ?
						VALVE_LIMIT : cfg.manual_valve_angle[7:0];
				if (cfg.manual_pump_request && !pump_running) begin
					pump_running = 1'b1;
					pump_elapsed = '0;
				end
			end
		end
		r.pump_on = pump_running;
		r.buzzer_on = buzzer_active;
		r.valve_angle = valve_position;
		r.pump_locked = pump_lock;
		r.buzzer_locked = buzzer_lock;
		r.reading_used = used;
		r.miss_count = miss_counter;
		expected_status.push_back(r);
	endfunction

	function int pending();
		return expected_status.size();
	endfunction

	task report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task check_status(result_t got);
		result_t want;
		if (expected_status.size() == 0) begin
			report_mismatch("result with none outstanding", 0, 0);
			return;
		end
		want = expected_status.pop_front();
		if (got.pump_on != want.pump_on)
			report_mismatch("pump_on", got.pump_on, want.pump_on);
		if (got.buzzer_on != want.buzzer_on)
			report_mismatch("buzzer_on", got.buzzer_on, want.buzzer_on);
		if (got.valve_angle != want.valve_angle)
			report_mismatch("valve_angle", got.valve_angle, want.valve_angle);
		if (got.pump_locked != want.pump_locked)
			report_mismatch("pump_locked", got.pump_locked, want.pump_locked);
		if (got.buzzer_locked != want.buzzer_locked)
			report_mismatch("buzzer_locked", got.buzzer_locked, want.buzzer_locked);
		if (got.reading_used != want.reading_used)
			report_mismatch("reading_used", got.reading_used, want.reading_used);
		if (got.miss_count != want.miss_count)
			report_mismatch("miss_count", got.miss_count, want.miss_count);
	endtask
endclass

module tank_level_pump_alarm_controller_core_test;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [14:0] echo_us;
	logic out_valid;
	logic out_ready;
	logic pump_on;
	logic buzzer_on;
	logic [7:0] valve_angle;
	logic pump_locked;
	logic buzzer_locked;
	logic reading_used;
	logic [7:0] miss_count;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pump_alarm_tracker tracker;
	result_t seen_result;
	bit in_idle_on, out_idle_on, hold_req;
	int ready_gap;
	int cycle_count;

	tank_level_pump_alarm_controller_core dut (.*);

	assign seen_result = {pump_on, buzzer_on, valve_angle, pump_locked, buzzer_locked,
		reading_used, miss_count};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Result side: random back-pressure, plus one long hold-off when requested.
	initial begin
		out_ready = 1'b0;
		ready_gap = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (ready_gap > 0) begin
				out_ready <= 1'b0;
				ready_gap--;
			end else begin
				out_ready <= 1'b1;
				ready_gap = out_idle_on ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			tracker.check_status(seen_result);

	task send(req_t req, logic [14:0] echo);
		int gap;
		gap = in_idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		echo_us <= echo;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_event(req, echo);
	endtask

	// Stop offering events and wait until every outstanding result has come back.
	task drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_cfg(idx, data);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_run();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(30, 1));
	endfunction

	task random_cfg();
		int r;
		logic [CFG_DATA_W-1:0] v;
		r = $urandom_range(9);
		v = (r == 0) ? 16'd0 : (r == 1) ? 16'd32767 : (r == 2) ? 16'd25000 :
			16'($urandom_range(600, 100));
		cfg_write(CFG_LEVEL_THRESHOLD, v);
		cfg_write(CFG_PUMP_RUN, pick_run());
		cfg_write(CFG_BUZZER_RUN, pick_run());
		r = $urandom_range(19);
		v = (r == 0) ? 16'd0 : (r == 1) ? 16'd255 : 16'($urandom_range(8, 1));
		cfg_write(CFG_ERROR_LIMIT, v);
		cfg_write(CFG_MANUAL_ENABLE, 16'($urandom_range(9) < 3));
		case ($urandom_range(6))
			0: v = 16'h01FF;
			1: v = 16'h0100;
			2: v = 16'd0;
			3: v = 16'd180;
			4: v = 16'd181;
			5: v = 16'd255;
			default: v = 16'($urandom_range(511));
		endcase
		cfg_write(CFG_MANUAL_VALVE, v);
		cfg_write(CFG_MANUAL_PUMP, 16'($urandom_range(1)));
	endtask

	// Ticks keep the short runs finishing; echoes cluster around the threshold.
	task random_event();
		logic [14:0] thr, e;
		req_t req;
		thr = tracker.cfg.level_threshold_us;
		req = REQ_ECHO;
		e = 15'($urandom_range(32767));
		case ($urandom_range(9))
			0, 1, 2, 3, 4: req = REQ_TICK;
			5: e = 15'd0;
			6: e = thr + 15'($urandom_range(1));
			7: e = 15'($urandom_range(thr));
			8: e = 15'($urandom_range(32767, thr));
			default: ;
		endcase
		send(req, e);
	endtask

	task run_random_phase(int count, bit quiet, bit hold);
		drain();
		random_cfg();
		in_idle_on = !quiet && ($urandom_range(3) != 0);
		out_idle_on = !quiet && ($urandom_range(3) != 0);
		if (hold) begin
			in_idle_on = 1'b0;
			hold_req = 1'b1;
		end
		repeat (count) random_event();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		echo_us = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_LEVEL_THRESHOLD;
		cfg_data = '0;
		hold_req = 1'b0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		tracker = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Auto mode at reset settings: idle tick, threshold edge, miss run-up to the limit.
		send(REQ_TICK, 15'h7FFF);
		send(REQ_ECHO, 15'd291);
		send(REQ_ECHO, 15'd292);
		repeat (6) send(REQ_ECHO, 15'd0);
		send(REQ_ECHO, 15'h4000);
		send(REQ_ECHO, 15'd25000);

		// Zero-length and one-tick runs, and a limit of zero.
		drain();
		cfg_write(CFG_PUMP_RUN, 16'd0);
		cfg_write(CFG_BUZZER_RUN, 16'd1);
		cfg_write(CFG_ERROR_LIMIT, 16'd0);
		send(REQ_ECHO, 15'd1);
		send(REQ_TICK, 15'd0);
		send(REQ_ECHO, 15'd0);
		send(REQ_ECHO, 15'd300);
		send(REQ_ECHO, 15'd0);
		send(REQ_TICK, 15'd0);

		// Manual mode: the pump request overrides the lock, the angle is clamped.
		drain();
		cfg_write(CFG_MANUAL_ENABLE, 16'd1);
		cfg_write(CFG_MANUAL_VALVE, 16'd255);
		cfg_write(CFG_MANUAL_PUMP, 16'd1);
		send(REQ_ECHO, 15'd100);
		send(REQ_TICK, 15'd0);
		send(REQ_ECHO, 15'd0);
		send(REQ_ECHO, 15'h7FFF);
		drain();
		cfg_write(CFG_MANUAL_VALVE, 16'h01FF);
		send(REQ_ECHO, 15'd5);
		drain();
		cfg_write(CFG_MANUAL_VALVE, 16'h0100);
		cfg_write(CFG_MANUAL_PUMP, 16'd0);
		send(REQ_ECHO, 15'd5);
		drain();
		cfg_write(CFG_MANUAL_VALVE, 16'd0);
		send(REQ_ECHO, 15'd5);
		drain();
		cfg_write(CFG_MANUAL_VALVE, 16'd181);
		send(REQ_ECHO, 15'd5);

		// Threshold extremes back in auto mode.
		drain();
		cfg_write(CFG_MANUAL_ENABLE, 16'd0);
		cfg_write(CFG_LEVEL_THRESHOLD, 16'd0);
		send(REQ_ECHO, 15'd1);
		drain();
		cfg_write(CFG_LEVEL_THRESHOLD, 16'd32767);
		send(REQ_ECHO, 15'h7FFF);

		// Miss counter climbing all the way to its 8-bit ceiling.
		drain();
		cfg_write(CFG_LEVEL_THRESHOLD, 16'd291);
		cfg_write(CFG_ERROR_LIMIT, 16'd255);
		repeat (257) send(REQ_ECHO, 15'd0);
		send(REQ_ECHO, 15'd500);

		for (int p = 0; p < 10; p++)
			run_random_phase(100, p == 1, p == 4);

		drain();
		if (tracker.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
